FILE: sv/sss_pkg.sv
// Shared types and constants for the sorted-matrix staircase search block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package sss_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 6;
	localparam int DIM_W  = 7;
	localparam int CFG_W  = 1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [CFG_W-1:0] CFG_NUM_ROWS = 1'b0;
	localparam logic [CFG_W-1:0] CFG_NUM_COLS = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic mem_wr;
		logic start;
		logic walk;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic exit;
	} stat_t;

endpackage
`default_nettype wire

FILE: sv/sss_ctrl.sv
// Controller state machine for the staircase search: input handshake,
// walk sequencing and output register valid. Depends on sss_pkg.
`default_nettype none
module sss_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          opcode,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire sss_pkg::stat_t stat,
	output sss_pkg::cmd_t      cmd
);
	import sss_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_SEARCH)
					state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (stat.exit || stat.hit)
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.mem_wr = accept && opcode == OP_WRITE;
				cmd.start  = accept && opcode == OP_SEARCH;
			end
			ST_WALK: begin
				cmd.walk   = 1'b1;
				cmd.finish = stat.exit || stat.hit;
			end
			ST_DONE: begin
				cmd.out_load = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: sv/sss_dp.sv
// Datapath for the staircase search: element memory, size registers,
// walk position counters, target compare and result register. Depends on sss_pkg.
`default_nettype none
module sss_dp #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sss_pkg::CFG_W-1:0]     cfg_index,
	input  wire logic [sss_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic [sss_pkg::IDX_W-1:0]     row_index,
	input  wire logic [sss_pkg::IDX_W-1:0]     col_index,
	input  wire logic signed [sss_pkg::DATA_W-1:0] value,
	input  wire sss_pkg::cmd_t                 cmd,
	output sss_pkg::stat_t                     stat,
	output logic                               found
);
	import sss_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] target_q;
	logic [DIM_W-1:0]         num_rows_q;
	logic [DIM_W-1:0]         num_cols_q;
	logic [DIM_W-1:0]         rows;
	logic [DIM_W-1:0]         cols;
	logic [DIM_W-1:0]         r_q;
	logic [DIM_W-1:0]         c_q;
	logic [DIM_W-1:0]         r_nxt;
	logic [DIM_W-1:0]         c_nxt;
	logic [DIM_W-1:0]         c_rd;
	logic [31:0]              rd_lin;
	logic [31:0]              wr_lin;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            wr_addr;
	logic                     wr_ok;
	logic                     res_q;
	logic                     found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_RESET;
			num_cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_ROWS: num_rows_q <= cfg_data;
				CFG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rows = num_rows_q;
		cols = num_cols_q;
		if (32'(num_rows_q) > 32'(MAX_ROWS))
			rows = DIM_W'(MAX_ROWS);
		if (32'(num_cols_q) > 32'(MAX_COLS))
			cols = DIM_W'(MAX_COLS);
	end

	assign stat.exit = !((r_q < rows) && (c_q != '0));
	assign stat.hit  = (rdata_q == target_q);

	always_comb begin
		r_nxt = r_q;
		c_nxt = c_q;
		if (cmd.start) begin
			r_nxt = '0;
			c_nxt = cols;
		end else if (cmd.walk && !stat.exit && !stat.hit) begin
			if (rdata_q > target_q)
				c_nxt = c_q - DIM_W'(1);
			else
				r_nxt = r_q + DIM_W'(1);
		end
	end

	assign c_rd    = c_nxt - DIM_W'(1);
	assign rd_lin  = 32'(r_nxt) * 32'(MAX_COLS) + 32'(c_rd);
	assign rd_addr = rd_lin[AW-1:0];
	assign wr_lin  = 32'(row_index) * 32'(MAX_COLS) + 32'(col_index);
	assign wr_addr = wr_lin[AW-1:0];
	assign wr_ok   = (32'(row_index) < 32'(MAX_ROWS)) && (32'(col_index) < 32'(MAX_COLS));

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok)
			mem[wr_addr] <= value;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else begin
			r_q <= r_nxt;
			c_q <= c_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			target_q <= value;
		if (cmd.finish)
			res_q <= stat.hit && !stat.exit;
		if (cmd.out_load)
			found_q <= res_q;
	end

	assign found = found_q;

endmodule
`default_nettype wire

FILE: sv/sorted_matrix_staircase_search_top.sv
// Top level of the sorted-matrix staircase search block.
// Joins sss_ctrl and sss_dp; depends on sss_pkg.
//
// Input channel (in_valid/in_ready): one beat per item. opcode OP_WRITE
// stores value at (row_index, col_index) and gives no result;
// writes outside MAX_ROWS x MAX_COLS are dropped. opcode OP_SEARCH walks
// from the top-right element of the num_rows x num_cols matrix in use.
// Output channel (out_valid/out_ready): one beat with found per search.
// Configuration: cfg_we writes cfg_data to num_rows (index 0) or num_cols
// (index 1) at once; write only while idle.
// Rate: a search is accepted, then walks one step per cycle (at most rows + cols
// steps, the last of which hits or leaves the matrix), then loads the output
// register. The next item is taken once the result sits in the output register.
// A stalled receiver holds the result; a following search waits at its
// end until the output register frees. Reset sets both sizes to 64 and
// empties the output register; element memory is not cleared.
`default_nettype none
module sorted_matrix_staircase_search_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sss_pkg::CFG_W-1:0]         cfg_index,
	input  wire logic [sss_pkg::DIM_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              opcode,
	input  wire logic [sss_pkg::IDX_W-1:0]         row_index,
	input  wire logic [sss_pkg::IDX_W-1:0]         col_index,
	input  wire logic signed [sss_pkg::DATA_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   found
);
	import sss_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sss_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.found     (found)
	);

endmodule
`default_nettype wire
